// ===== sv/id_allocator_free_stack_core_macros.svh =====
// Assertion macros used by the allocator controller.
`ifndef ID_ALLOCATOR_FREE_STACK_CORE_MACROS_SVH
`define ID_ALLOCATOR_FREE_STACK_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define IDA_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define IDA_NEVER(name, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define IDA_ASSERT(name, prop, msg)
`define IDA_NEVER(name, expr, msg)
`endif

`endif

// ===== sv/idalloc_pkg.sv =====
package idalloc_pkg;

	localparam int ID_W       = 16;
	localparam int FREE_DEPTH = 256;
	localparam int ADDR_W     = $clog2(FREE_DEPTH);
	localparam int CNT_W      = $clog2(FREE_DEPTH + 1);

	localparam logic [ID_W-1:0] ID_MAX = '1;

	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_INVALID = 2'd1;
	localparam logic [1:0] STAT_FULL    = 2'd2;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [ID_W-1:0]   wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

	typedef struct packed {
		logic            valid;
		logic            pop;
		logic [ID_W-1:0] gid;
		logic [1:0]      status;
	} result_t;

endpackage

// ===== sv/idalloc_stack_ram.sv =====
module idalloc_stack_ram
	import idalloc_pkg::*;
(
	input  logic            clk,
	input  ram_req_t        req,
	output logic [ID_W-1:0] rdata
);

	logic [ID_W-1:0] mem_q [FREE_DEPTH];
	logic [ID_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem_q[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/idalloc_ctrl.sv =====
`include "id_allocator_free_stack_core_macros.svh"

module idalloc_ctrl
	import idalloc_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid_s1,
	input  logic            op_s1,
	input  logic [ID_W-1:0] id_s1,
	output ram_req_t        req,
	output result_t         rsp
);

	logic [ID_W-1:0]  hw_q;
	logic [ID_W-1:0]  hw_d;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_d;
	logic [CNT_W-1:0] cnt_dec;
	logic [ID_W-1:0]  hw_inc;

	assign cnt_dec = cnt_q - 1'b1;
	assign hw_inc  = hw_q + 1'b1;

	always_comb begin
		hw_d       = hw_q;
		cnt_d      = cnt_q;
		req.we     = 1'b0;
		req.waddr  = cnt_q[ADDR_W-1:0];
		req.wdata  = id_s1;
		req.re     = 1'b0;
		req.raddr  = cnt_dec[ADDR_W-1:0];
		rsp.valid  = valid_s1;
		rsp.pop    = 1'b0;
		rsp.gid    = '0;
		rsp.status = STAT_OK;
		if (valid_s1) begin
			if (op_s1 == OP_ALLOC) begin
				if (cnt_q != '0) begin
					req.re  = 1'b1;
					rsp.pop = 1'b1;
					cnt_d   = cnt_dec;
				end else if (hw_q != ID_MAX) begin
					hw_d    = hw_inc;
					rsp.gid = hw_inc;
				end else begin
					rsp.status = STAT_INVALID;
				end
			end else begin
				if (id_s1 == '0 || id_s1 > hw_q) begin
					rsp.status = STAT_INVALID;
				end else if (id_s1 == hw_q) begin
					hw_d = hw_q - 1'b1;
				end else if (cnt_q == CNT_W'(FREE_DEPTH)) begin
					rsp.status = STAT_FULL;
				end else begin
					req.we = 1'b1;
					cnt_d  = cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_q  <= '0;
			cnt_q <= '0;
		end else begin
			hw_q  <= hw_d;
			cnt_q <= cnt_d;
		end
	end

	`IDA_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(FREE_DEPTH), "free count above depth")
	`IDA_NEVER(a_push_pop, req.we && req.re, "push and pop in one cycle")
	`IDA_ASSERT(a_push_grow, req.we |=> cnt_q == $past(cnt_q) + CNT_W'(1), "push lost")
	`IDA_ASSERT(a_idle_hold, !valid_s1 |=> $stable(hw_q) && $stable(cnt_q), "state moved idle")

endmodule

// ===== sv/id_allocator_free_stack_core.sv =====
// A word taken on start passes through the s1 and s2 registers and then gives its result with done high.
// Throughput: one word per cycle; busy is never raised and start may stay high.
// The pop data comes from the registered read port of the free stack memory.
// Reset clears the high-water mark, the free count and the pipeline valids.
// The free stack memory is not cleared; no word waits on it. The receiver cannot stall.
module id_allocator_free_stack_core
	import idalloc_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  logic            op,
	input  logic [ID_W-1:0] release_id,
	output logic            done,
	output logic [ID_W-1:0] granted_id,
	output logic [1:0]      status
);

	logic            valid_s1;
	logic            op_s1;
	logic [ID_W-1:0] id_s1;
	logic            valid_s2;
	logic            pop_s2;
	logic [ID_W-1:0] gid_s2;
	logic [1:0]      status_s2;
	logic [ID_W-1:0] rdata;
	ram_req_t        req;
	result_t         rsp;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= rsp.valid;
		end
	end

	always_ff @(posedge clk) begin
		op_s1     <= op;
		id_s1     <= release_id;
		pop_s2    <= rsp.pop;
		gid_s2    <= rsp.gid;
		status_s2 <= rsp.status;
	end

	idalloc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.op_s1    (op_s1),
		.id_s1    (id_s1),
		.req      (req),
		.rsp      (rsp)
	);

	idalloc_stack_ram u_ram (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);

	assign done       = valid_s2;
	assign granted_id = pop_s2 ? rdata : gid_s2;
	assign status     = status_s2;

endmodule
